FILE: hw/rtl/lrc_pkg.sv
package lrc_pkg;

    localparam int AW   = 48;
    localparam int LW   = 32;
    localparam int RLW  = 33;
    localparam int SKW  = 8;
    localparam int SLW  = 4;
    localparam int UW   = 16;
    localparam int PSW  = 5;
    localparam int WSW  = 35;

    localparam logic [PSW-1:0] PAGE_SHIFT_RST = 5'd12;
    localparam logic [UW-1:0]  USES_MAX       = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_GET   = 2'd0,
        OP_PUT   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS_REG  = 3'd1,
        ST_NO_FREE   = 3'd2,
        ST_REG_FAIL  = 3'd3,
        ST_PUT_DONE  = 3'd4,
        ST_PUT_UNDER = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_PUT_RD,
        S_PUT_DO,
        S_CLEAR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [AW-1:0]  base;
        logic [RLW-1:0] len;
        logic [SKW-1:0] sock;
    } entry_t;

    typedef struct packed {
        op_t            op;
        logic [AW-1:0]  addr;
        logic [LW-1:0]  len;
        logic [SKW-1:0] sock;
        logic [SLW-1:0] slot;
        logic           reg_ok;
    } req_t;

    typedef struct packed {
        status_t        status;
        logic [SLW-1:0] slot;
        logic [AW-1:0]  base;
        logic [RLW-1:0] len;
        logic [UW-1:0]  uses;
    } result_t;

endpackage

FILE: hw/rtl/lrc_if.sv
interface lrc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [47:0] address;
    logic [31:0] length;
    logic [7:0]  socket_id;
    logic [3:0]  slot;
    logic        register_ok;

    modport source (output valid, operation, address, length, socket_id, slot,
                    register_ok, input ready);
    modport sink (input valid, operation, address, length, socket_id, slot,
                  register_ok, output ready);
endinterface

interface lrc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  slot_out;
    logic [47:0] region_base;
    logic [32:0] region_length;
    logic [15:0] use_count;

    modport source (output valid, status, slot_out, region_base, region_length,
                    use_count, input ready);
    modport sink (input valid, status, slot_out, region_base, region_length,
                  use_count, output ready);
endinterface

interface lrc_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] page_shift;

    modport source (output valid, page_shift, input ready);
    modport sink (input valid, page_shift, output ready);
endinterface

FILE: hw/rtl/lrc_store.sv
module lrc_store #(
    parameter int ENTRIES = 6,
    localparam int IW = $clog2(ENTRIES)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [IW-1:0]   waddr,
    input  lrc_pkg::entry_t wdata,
    input  logic [IW-1:0]   raddr,
    output lrc_pkg::entry_t rdata
);
    import lrc_pkg::*;

    entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/lrc_ctrl.sv
module lrc_ctrl #(
    parameter int ENTRIES = 6,
    localparam int IW = $clog2(ENTRIES),
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  lrc_pkg::req_t             req,
    input  logic [lrc_pkg::PSW-1:0]   page_shift,
    input  logic                      out_free,
    output logic                      res_load,
    output lrc_pkg::result_t          res,
    output logic                      mem_we,
    output logic [IW-1:0]             mem_waddr,
    output lrc_pkg::entry_t           mem_wdata,
    output logic [IW-1:0]             mem_raddr,
    input  lrc_pkg::entry_t           mem_rdata
);
    import lrc_pkg::*;

    state_t         state_reg, state_next;
    req_t           req_reg, req_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           hit_reg, hit_next;
    logic [IW-1:0]  hit_idx_reg, hit_idx_next;
    logic [IW-1:0]  hit_rank_reg, hit_rank_next;
    entry_t         hit_ent_reg, hit_ent_next;
    result_t        res_reg, res_next;
    logic           valid_reg [ENTRIES];
    logic           valid_next [ENTRIES];
    logic [UW-1:0]  uses_reg [ENTRIES];
    logic [UW-1:0]  uses_next [ENTRIES];
    logic [IW-1:0]  rank_reg [ENTRIES];
    logic [IW-1:0]  rank_next [ENTRIES];

    logic [IW-1:0]  old_idx;
    logic [IW-1:0]  cmp_idx;
    logic [IW-1:0]  put_idx;
    logic [IW-1:0]  front_idx;
    logic           do_front;
    logic           cmp_hit;
    logic [AW-1:0]  mask;
    logic [WSW-1:0] wide_size;
    logic [WSW-1:0] round_size;
    logic [AW-1:0]  fill_base;
    logic [RLW-1:0] fill_len;
    entry_t         put_ent;
    logic [UW-1:0]  hit_uses;

    assign req_ready = (state_reg == S_IDLE);
    assign res       = res_reg;
    assign cmp_idx   = IW'(cnt_reg - CW'(1));
    assign put_idx   = req_reg.slot[IW-1:0];

    // The entry holding the oldest rank is the replacement victim.
    always_comb
    begin
        old_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (rank_reg[i] == IW'(ENTRIES - 1))
            begin
                old_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        mask       = (AW'(1) << page_shift) - AW'(1);
        wide_size  = WSW'(req_reg.len) + WSW'(req_reg.addr & mask);
        round_size = (wide_size + WSW'(mask)) & ~WSW'(mask);
        fill_base  = req_reg.addr & ~mask;
        fill_len   = round_size[RLW-1:0];
    end

    // An empty entry never hits, and a put reads it as zero base and length.
    assign cmp_hit = valid_reg[cmp_idx] && (mem_rdata.sock == req_reg.sock)
                     && (req_reg.addr >= mem_rdata.base)
                     && (({1'b0, req_reg.addr} + (AW + 1)'(req_reg.len))
                         <= ((AW + 1)'(mem_rdata.base) + (AW + 1)'(mem_rdata.len)));
    assign put_ent  = valid_reg[put_idx] ? mem_rdata : '0;
    assign hit_uses = (uses_reg[hit_idx_reg] == USES_MAX) ? USES_MAX
                      : uses_reg[hit_idx_reg] + UW'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.op)
                        OP_GET:   state_next = S_SEARCH;
                        OP_PUT:   state_next = S_PUT_RD;
                        OP_CLEAR: state_next = S_CLEAR;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (cnt_reg == CW'(ENTRIES))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: state_next = S_FINISH;
            S_PUT_RD: state_next = S_PUT_DO;
            S_PUT_DO: state_next = S_FINISH;
            S_CLEAR:  state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_next      = req_reg;
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_rank_next = hit_rank_reg;
        hit_ent_next  = hit_ent_reg;
        res_next      = res_reg;
        valid_next    = valid_reg;
        uses_next     = uses_reg;
        mem_we        = 1'b0;
        mem_waddr     = old_idx;
        mem_wdata     = '{base: fill_base, len: fill_len, sock: req_reg.sock};
        mem_raddr     = (state_reg == S_PUT_RD) ? put_idx : cnt_reg[IW-1:0];
        res_load      = 1'b0;
        do_front      = 1'b0;
        front_idx     = old_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    cnt_next = '0;
                    hit_next = 1'b0;
                end
            end
            S_SEARCH:
            begin
                cnt_next = cnt_reg + CW'(1);
                if ((cnt_reg != '0) && cmp_hit
                    && (!hit_reg || (rank_reg[cmp_idx] < hit_rank_reg)))
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = cmp_idx;
                    hit_rank_next = rank_reg[cmp_idx];
                    hit_ent_next  = mem_rdata;
                end
            end
            S_DECIDE:
            begin
                if (hit_reg)
                begin
                    uses_next[hit_idx_reg] = hit_uses;
                    do_front  = 1'b1;
                    front_idx = hit_idx_reg;
                    res_next  = '{ST_HIT, SLW'(hit_idx_reg), hit_ent_reg.base,
                                  hit_ent_reg.len, hit_uses};
                end
                else if (uses_reg[old_idx] != '0)
                begin
                    res_next = '{ST_NO_FREE, SLW'(old_idx), '0, '0, uses_reg[old_idx]};
                end
                else if (!req_reg.reg_ok)
                begin
                    valid_next[old_idx] = 1'b0;
                    res_next = '{ST_REG_FAIL, SLW'(old_idx), '0, '0, '0};
                end
                else
                begin
                    mem_we              = 1'b1;
                    valid_next[old_idx] = 1'b1;
                    uses_next[old_idx]  = UW'(1);
                    do_front            = 1'b1;
                    res_next = '{ST_MISS_REG, SLW'(old_idx), fill_base, fill_len, UW'(1)};
                end
            end
            S_PUT_DO:
            begin
                if (32'(req_reg.slot) >= ENTRIES)
                begin
                    res_next = '{ST_PUT_UNDER, req_reg.slot, '0, '0, '0};
                end
                else if (uses_reg[put_idx] == '0)
                begin
                    res_next = '{ST_PUT_UNDER, req_reg.slot, put_ent.base, put_ent.len, '0};
                end
                else
                begin
                    uses_next[put_idx] = uses_reg[put_idx] - UW'(1);
                    res_next = '{ST_PUT_DONE, req_reg.slot, put_ent.base, put_ent.len,
                                 uses_reg[put_idx] - UW'(1)};
                end
            end
            S_CLEAR:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (uses_reg[i] == '0)
                    begin
                        valid_next[i] = 1'b0;
                    end
                end
                res_next = '{ST_CLEARED, '0, '0, '0, '0};
            end
            S_FINISH:
            begin
                res_load = out_free;
            end
            default:
            begin
            end
        endcase

        rank_next = rank_reg;
        if (do_front)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (rank_reg[j] < rank_reg[front_idx])
                begin
                    rank_next[j] = rank_reg[j] + IW'(1);
                end
            end
            rank_next[front_idx] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                uses_reg[i]  <= '0;
                rank_reg[i]  <= IW'(i);
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            uses_reg  <= uses_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        cnt_reg      <= cnt_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_rank_reg <= hit_rank_next;
        hit_ent_reg  <= hit_ent_next;
        res_reg      <= res_next;
    end

endmodule

FILE: hw/rtl/lru_region_registration_cache_core.sv
// Cache of registered memory regions with most-recent-first replacement.
// The req channel takes one item per operation: get (look up or register a
// region), put (release one use of a slot) or clear (drop unused entries).
// Each get, put or clear item gives exactly one item on the rsp channel;
// operation code 3 is dropped without a result.
// The cfg channel writes page_shift and is always ready; write it only while
// the cache is idle.
// A get reads the region memory one entry per cycle while searching, then
// decides and loads the result register once the output is free. A put
// reads its slot and then updates it; a clear drops unused entries. The next
// item is accepted in the cycle after the result is loaded.
// The result sits in an output register; while the receiver stalls the
// cache still accepts and works on one more item, then waits to load it.
// Reset empties all entries, zeroes use counts, restores the recency order
// to entry index order and sets page_shift to 12. No clearing pass is needed.
module lru_region_registration_cache_core #(
    parameter int ENTRIES = 6
) (
    input  logic   clk,
    input  logic   rst_n,
    lrc_req_if.sink   req,
    lrc_rsp_if.source rsp,
    lrc_cfg_if.sink   cfg
);
    import lrc_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    logic           rsp_valid_reg;
    result_t        rsp_data_reg;
    logic [PSW-1:0] page_shift_reg;
    logic           out_free;
    logic           res_load;
    result_t        res;
    req_t           req_data;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    logic [IW-1:0]  mem_raddr;
    entry_t         mem_wdata;
    entry_t         mem_rdata;

    assign req_data = '{op: op_t'(req.operation), addr: req.address, len: req.length,
                        sock: req.socket_id, slot: req.slot, reg_ok: req.register_ok};
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    lrc_store #(.ENTRIES(ENTRIES)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lrc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .req        (req_data),
        .page_shift (page_shift_reg),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            page_shift_reg <= PAGE_SHIFT_RST;
        end
        else
        begin
            if (res_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                page_shift_reg <= cfg.page_shift;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_data_reg.status;
    assign rsp.slot_out      = rsp_data_reg.slot;
    assign rsp.region_base   = rsp_data_reg.base;
    assign rsp.region_length = rsp_data_reg.len;
    assign rsp.use_count     = rsp_data_reg.uses;

endmodule

FILE: hw/rtl/lrc_checker.sv
module lrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic [3:0]  slot_out,
    input logic [47:0] region_base,
    input logic [32:0] region_length,
    input logic [15:0] use_count
);
    import lrc_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(slot_out)
        && $stable(region_base) && $stable(region_length) && $stable(use_count))
        else $error("stalled result changed");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status != 3'd7)
        else $error("undefined status code");

    a_hit_used: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_HIT |-> use_count != 16'd0)
        else $error("hit with zero use count");

    a_fill_once: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_MISS_REG |-> use_count == 16'd1)
        else $error("new region not used exactly once");

    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_REG_FAIL |->
        region_base == 48'd0 && region_length == 33'd0 && use_count == 16'd0)
        else $error("failed registration reports a region");

endmodule

bind lru_region_registration_cache_core lrc_checker u_lrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .slot_out      (rsp.slot_out),
    .region_base   (rsp.region_base),
    .region_length (rsp.region_length),
    .use_count     (rsp.use_count)
);

FILE: verif/lru_region_registration_cache_core_test.sv
module lru_region_registration_cache_core_test;
    import lrc_pkg::*;

    typedef struct {
        status_t     status;
        logic [3:0]  slot;
        logic [47:0] base;
        logic [32:0] len;
        logic [15:0] uses;
    } region_result_t;

    int cycle;
    int mismatches;

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at cycle %0d: %s", cycle, msg);
    endtask

    class region_scoreboard;
        logic [47:0] base_q [6];
        logic [32:0] len_q [6];
        logic [7:0]  sock_q [6];
        bit          valid_q [6];
        logic [15:0] uses_q [6];
        int          rank_q [6];
        logic [4:0]  shift;
        region_result_t pending[$];
        int checked;

        function new();
            for (int i = 0; i < 6; i++)
            begin
                base_q[i] = '0;
                len_q[i] = '0;
                sock_q[i] = '0;
                valid_q[i] = 0;
                uses_q[i] = '0;
                rank_q[i] = i;
            end
            shift = PAGE_SHIFT_RST;
            checked = 0;
        endfunction

        function void promote(int e);
            int r;
            r = rank_q[e];
            for (int j = 0; j < 6; j++)
                if (rank_q[j] < r)
                    rank_q[j]++;
            rank_q[e] = 0;
            if (uses_q[e] != USES_MAX)
                uses_q[e]++;
        endfunction

        function void push(status_t st, int s, logic [47:0] b, logic [32:0] l,
                           logic [15:0] u);
            region_result_t x;
            x.status = st;
            x.slot = s[3:0];
            x.base = b;
            x.len = l;
            x.uses = u;
            pending.push_back(x);
        endfunction

        function void note_request(op_t op, logic [47:0] addr, logic [31:0] len,
                                   logic [7:0] sock, logic [3:0] slot, bit ok);
            logic [63:0] mask, sz, lim, span;
            int oldest;
            if (op == OP_GET)
            begin
                for (int r = 0; r < 6; r++)
                    for (int i = 0; i < 6; i++)
                    begin
                        span = {16'd0, base_q[i]} + {31'd0, len_q[i]};
                        lim = {16'd0, addr} + {32'd0, len};
                        if (rank_q[i] == r && valid_q[i] && sock_q[i] == sock &&
                            addr >= base_q[i] && lim <= span)
                        begin
                            promote(i);
                            push(ST_HIT, i, base_q[i], len_q[i], uses_q[i]);
                            return;
                        end
                    end
                mask = (64'd1 << shift) - 64'd1;
                sz = {32'd0, len} + ({16'd0, addr} & mask);
                sz = (sz + mask) & ~mask;
                oldest = 0;
                for (int i = 0; i < 6; i++)
                    if (rank_q[i] == 5)
                        oldest = i;
                if (uses_q[oldest] != 0)
                begin
                    push(ST_NO_FREE, oldest, '0, '0, uses_q[oldest]);
                    return;
                end
                valid_q[oldest] = 0;
                base_q[oldest] = '0;
                len_q[oldest] = '0;
                if (!ok)
                begin
                    push(ST_REG_FAIL, oldest, '0, '0, '0);
                    return;
                end
                base_q[oldest] = addr & ~mask[47:0];
                len_q[oldest] = sz[32:0];
                sock_q[oldest] = sock;
                valid_q[oldest] = 1;
                promote(oldest);
                push(ST_MISS_REG, oldest, base_q[oldest], len_q[oldest],
                     uses_q[oldest]);
            end
            else if (op == OP_PUT)
            begin
                if (slot >= 6)
                    push(ST_PUT_UNDER, int'(slot), '0, '0, '0);
                else if (uses_q[slot] == 0)
                    push(ST_PUT_UNDER, int'(slot), base_q[slot], len_q[slot], '0);
                else
                begin
                    uses_q[slot]--;
                    push(ST_PUT_DONE, int'(slot), base_q[slot], len_q[slot], uses_q[slot]);
                end
            end
            else if (op == OP_CLEAR)
            begin
                for (int i = 0; i < 6; i++)
                    if (uses_q[i] == 0)
                    begin
                        valid_q[i] = 0;
                        base_q[i] = '0;
                        len_q[i] = '0;
                    end
                push(ST_CLEARED, 0, '0, '0, '0);
            end
        endfunction

        task check_result(region_result_t got);
            region_result_t w;
            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("result arrived with nothing outstanding");
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status)
                report_mismatch($sformatf("status %0d, wanted %0d", got.status, w.status));
            if (got.slot !== w.slot)
                report_mismatch($sformatf("slot %0d, wanted %0d", got.slot, w.slot));
            if (got.base !== w.base)
                report_mismatch($sformatf("base %h, wanted %h", got.base, w.base));
            if (got.len !== w.len)
                report_mismatch($sformatf("length %h, wanted %h", got.len, w.len));
            if (got.uses !== w.uses)
                report_mismatch($sformatf("uses %0d, wanted %0d", got.uses, w.uses));
        endtask
    endclass

    logic clk;
    logic rst_n;
    lrc_req_if req ();
    lrc_rsp_if rsp ();
    lrc_cfg_if cfg ();

    region_scoreboard board;
    int hold_off;
    bit stall_on;

    lru_region_registration_cache_core #(.ENTRIES(6)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source),
        .cfg(cfg.sink)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > 600000)
        begin
            $display("timeout with %0d results outstanding", board.pending.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls per item, plus long hold-offs on request.
    initial
    begin
        int w;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                rsp.ready <= 1'b0;
                hold_off--;
            end
            else if (!rsp.ready)
            begin
                w = stall_on ? $urandom_range(0, 12) : 0;
                repeat (w) @(negedge clk);
                rsp.ready <= 1'b1;
            end
            else if (stall_on && $urandom_range(0, 3) == 0)
                rsp.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        region_result_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.status = status_t'(rsp.status);
            got.slot = rsp.slot_out;
            got.base = rsp.region_base;
            got.len = rsp.region_length;
            got.uses = rsp.use_count;
            board.check_result(got);
        end
    end

    task automatic send_item(op_t op, logic [47:0] a, logic [31:0] l,
                             logic [7:0] s, logic [3:0] sl, bit ok, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 12) : 0;
        repeat (w) @(negedge clk);
        req.valid = 1'b1;
        req.operation = op;
        req.address = a;
        req.length = l;
        req.socket_id = s;
        req.slot = sl;
        req.register_ok = ok;
        do
            @(posedge clk);
        while (!req.ready);
        board.note_request(op, a, l, s, sl, ok);
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_shift(logic [4:0] v);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.page_shift <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        board.shift = v;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_item(bit gaps, int span);
        int k;
        logic [47:0] a;
        logic [31:0] l;
        k = $urandom_range(0, 99);
        a = 48'({$urandom, $urandom});
        if (span < 48)
            a = a & ((48'd1 << span) - 48'd1);
        l = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 9000);
        if (k < 55)
            send_item(OP_GET, a, l, 8'($urandom_range(0, 3)), 4'($urandom),
                      $urandom_range(0, 7) != 0, gaps);
        else if (k < 62)
            send_item(OP_GET, 48'({$urandom, $urandom}), $urandom, 8'($urandom),
                      4'($urandom), 1'($urandom), gaps);
        else if (k < 90)
            send_item(OP_PUT, a, l, 8'd0,
                      4'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5)),
                      1'($urandom), gaps);
        else if (k < 95)
            send_item(OP_CLEAR, a, l, 8'($urandom), 4'($urandom), 1'($urandom), gaps);
        else
            send_item(OP_NONE, 48'({$urandom, $urandom}), $urandom, 8'($urandom),
                      4'($urandom), 1'($urandom), gaps);
    endtask

    initial
    begin
        logic [4:0] shifts [5] = '{5'd0, 5'd30, 5'd12, 5'd31, 5'd4};
        board = new();
        cycle = 0;
        hold_off = 0;
        stall_on = 0;
        mismatches = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_GET;
        req.address = '0;
        req.length = '0;
        req.socket_id = '0;
        req.slot = '0;
        req.register_ok = 1'b0;
        cfg.valid = 1'b0;
        cfg.page_shift = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, hits, underflow, full cache, failures, clear.
        send_item(OP_PUT, '0, '0, '0, 4'd0, 1'b0, 1'b0);
        send_item(OP_PUT, '0, '0, '0, 4'd15, 1'b0, 1'b0);
        send_item(OP_GET, 48'h0000_0000_1234, 32'd100, 8'd1, '0, 1'b0, 1'b0);
        send_item(OP_GET, 48'h0000_0000_1234, 32'd100, 8'd1, '0, 1'b1, 1'b0);
        send_item(OP_GET, 48'h0000_0000_1240, 32'd10, 8'd1, '0, 1'b1, 1'b0);
        send_item(OP_GET, 48'h0000_0000_1240, 32'd10, 8'd2, '0, 1'b1, 1'b0);
        send_item(OP_GET, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, '0, 1'b1, 1'b0);
        send_item(OP_GET, 48'h8000_0000_0000, 32'h8000_0000, 8'h80, '0, 1'b1, 1'b0);
        send_item(OP_GET, 48'h5555_5555_5555, 32'h5555_5555, 8'h55, '0, 1'b1, 1'b0);
        send_item(OP_GET, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA, 8'hAA, '0, 1'b1, 1'b0);
        send_item(OP_GET, 48'h1, 32'd1, 8'd3, '0, 1'b1, 1'b0);
        send_item(OP_PUT, '0, '0, '0, 4'd3, 1'b1, 1'b0);
        send_item(OP_NONE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF, 1'b1, 1'b0);
        send_item(OP_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0);
        for (int i = 0; i < 6; i++)
            send_item(OP_PUT, '0, '0, '0, i[3:0], 1'b0, 1'b0);
        send_item(OP_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            write_shift(shifts[p]);
            stall_on = (p != 1);
            if (p == 2)
                hold_off = 300;
            for (int n = 0; n < 390; n++)
                random_item(p != 3, p == 4 ? 16 : 48);
            drain();
        end

        $display("ran %0d results across page shifts 0, 4, 12, 30 and 31,", board.checked);
        $display("with hits, misses, full cache, puts, clears and receiver stalls");
        if (mismatches == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/lrc_pkg.sv
hw/rtl/lrc_if.sv
hw/rtl/lrc_store.sv
hw/rtl/lrc_ctrl.sv
hw/rtl/lru_region_registration_cache_core.sv
hw/rtl/lrc_checker.sv
verif/lru_region_registration_cache_core_test.sv
